FILE: rtl/plp_pkg.sv
// shared types and constants of the positional list unit
`default_nettype none
package plp_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    // compare width for position against count
    localparam int XW    = ((CW > 5) ? CW : 5) + 1;

    typedef enum logic [2:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_AT    = 3'd1,
        ACT_APPEND    = 3'd2,
        ACT_DEL_FIRST = 3'd3,
        ACT_DEL_AT    = 3'd4,
        ACT_DEL_LAST  = 3'd5,
        ACT_DISPLAY   = 3'd6,
        ACT_REPLACE   = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_POS   = 2'd3
    } t_status;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [31:0]   wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic signed [31:0] element;
        logic [3:0]         index;
        logic               has_element;
        t_status            status;
        logic               last;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/plp_ram.sv
// entry memory: one write port, one registered read port
`default_nettype none
module plp_ram
    import plp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_mem_req    i_req,
    output logic [31:0]      o_rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/plp_ctrl.sv
// command sequencer: decode, shift through memory, stream the list out
`default_nettype none
module plp_ctrl
    import plp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_action     i_action,
    input  wire logic [4:0]  i_position,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_result          o_result,
    output t_mem_req         o_mem,
    input  wire logic [31:0] i_rdata
);

    typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_FINAL, S_EMIT} t_state;
    typedef enum logic [1:0] {OP_NONE, OP_INS, OP_DEL, OP_REP} t_op;

    t_state        r_state,   n_state;
    logic [CW-1:0] r_count,   n_count;
    t_status       r_status,  n_status;
    t_op           r_op,      n_op;
    logic [AW-1:0] r_slot,    n_slot;
    logic [31:0]   r_word,    n_word;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic [CW-1:0] r_rd_left, n_rd_left;
    logic          r_wr_pend, n_wr_pend;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic [CW-1:0] r_em_idx,  n_em_idx;
    logic          r_rd_pend, n_rd_pend;
    logic [AW-1:0] r_rd_idx,  n_rd_idx;
    logic          r_out_valid, n_out_valid;
    t_result       r_out,     n_out;

    always_comb begin
        logic [XW-1:0] ext_pos;
        logic [XW-1:0] ext_cnt;
        logic          full;
        logic          empty;
        logic          ins_bad;
        logic          del_bad;
        logic          out_free;
        logic          consume;
        logic          issue;
        logic [31:0]   idx_wide;
        logic [AW-1:0] pos_slot;

        ext_pos  = XW'(i_position);
        ext_cnt  = XW'(r_count);
        full     = (r_count == CW'(DEPTH));
        empty    = (r_count == '0);
        ins_bad  = (i_position == 5'd0) || (ext_pos > ext_cnt + XW'(1));
        del_bad  = (i_position == 5'd0) || (ext_pos > ext_cnt);
        pos_slot = AW'(i_position - 5'd1);
        out_free = !r_out_valid || i_ready;
        consume  = 1'b0;
        issue    = 1'b0;
        idx_wide = 32'(r_rd_idx);

        n_state     = r_state;
        n_count     = r_count;
        n_status    = r_status;
        n_op        = r_op;
        n_slot      = r_slot;
        n_word      = r_word;
        n_rd_addr   = r_rd_addr;
        n_rd_left   = r_rd_left;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_em_idx    = r_em_idx;
        n_rd_pend   = r_rd_pend;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;

        o_ready   = (r_state == S_IDLE);
        o_mem     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_status = ST_OK;
                    n_op     = OP_NONE;
                    n_slot   = '0;
                    n_word   = i_value;
                    unique case (i_action)
                        ACT_INS_FRONT: begin
                            if (full) n_status = ST_FULL;
                            else      n_op     = OP_INS;
                        end
                        ACT_INS_AT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (ins_bad) begin
                                n_status = ST_POS;
                            end else begin
                                n_op   = OP_INS;
                                n_slot = pos_slot;
                            end
                        end
                        ACT_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_op   = OP_INS;
                                n_slot = AW'(r_count);
                            end
                        end
                        ACT_DEL_FIRST: begin
                            if (empty) n_status = ST_EMPTY;
                            else       n_op     = OP_DEL;
                        end
                        ACT_DEL_AT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (del_bad) begin
                                n_status = ST_POS;
                            end else begin
                                n_op   = OP_DEL;
                                n_slot = pos_slot;
                            end
                        end
                        ACT_DEL_LAST: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_op   = OP_DEL;
                                n_slot = AW'(r_count - CW'(1));
                            end
                        end
                        ACT_REPLACE: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (del_bad) begin
                                n_status = ST_POS;
                            end else begin
                                n_op   = OP_REP;
                                n_slot = pos_slot;
                            end
                        end
                        default: ; // display leaves the list alone
                    endcase
                    // shift plan: inserts walk down from the top, deletes walk up
                    if (n_op == OP_INS) begin
                        n_rd_addr = AW'(r_count - CW'(1));
                        n_rd_left = r_count - CW'(n_slot);
                    end else if (n_op == OP_DEL) begin
                        n_rd_addr = n_slot + AW'(1);
                        n_rd_left = r_count - CW'(1) - CW'(n_slot);
                    end else begin
                        n_rd_left = '0;
                    end
                    n_em_idx  = '0;
                    n_rd_pend = 1'b0;
                    n_state   = (n_op == OP_NONE) ? S_EMIT : S_SHIFT;
                end
            end
            S_SHIFT: begin
                // write back the word read last cycle one slot over
                o_mem.we    = r_wr_pend;
                o_mem.waddr = r_wr_addr;
                o_mem.wdata = i_rdata;
                if (r_rd_left != '0) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_rd_addr;
                    n_rd_left   = r_rd_left - CW'(1);
                    n_wr_pend   = 1'b1;
                    if (r_op == OP_INS) begin
                        n_wr_addr = r_rd_addr + AW'(1);
                        n_rd_addr = r_rd_addr - AW'(1);
                    end else begin
                        n_wr_addr = r_rd_addr - AW'(1);
                        n_rd_addr = r_rd_addr + AW'(1);
                    end
                end else if (!r_wr_pend) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_mem.we    = (r_op == OP_INS) || (r_op == OP_REP);
                o_mem.waddr = r_slot;
                o_mem.wdata = r_word;
                if (r_op == OP_INS) n_count = r_count + CW'(1);
                if (r_op == OP_DEL) n_count = r_count - CW'(1);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (empty) begin
                    // status only transaction
                    if (out_free) begin
                        n_out_valid       = 1'b1;
                        n_out.element     = '0;
                        n_out.index       = '0;
                        n_out.has_element = 1'b0;
                        n_out.status      = r_status;
                        n_out.last        = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    consume = r_rd_pend && out_free;
                    issue   = (r_em_idx < r_count) && (!r_rd_pend || consume);
                    o_mem.re    = issue;
                    o_mem.raddr = r_em_idx[AW-1:0];
                    if (issue) begin
                        n_em_idx = r_em_idx + CW'(1);
                        n_rd_idx = r_em_idx[AW-1:0];
                    end
                    n_rd_pend = issue || (r_rd_pend && !consume);
                    if (consume) begin
                        n_out_valid       = 1'b1;
                        n_out.element     = i_rdata;
                        n_out.index       = idx_wide[3:0];
                        n_out.has_element = 1'b1;
                        n_out.status      = r_status;
                        n_out.last        = (CW'(r_rd_idx) + CW'(1) == r_count);
                        if (n_out.last) n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wr_pend   <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_rd_left   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wr_pend   <= n_wr_pend;
            r_rd_pend   <= n_rd_pend;
            r_rd_left   <= n_rd_left;
            r_out_valid <= n_out_valid;
        end
        r_status  <= n_status;
        r_op      <= n_op;
        r_slot    <= n_slot;
        r_word    <= n_word;
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr;
        r_em_idx  <= n_em_idx;
        r_rd_idx  <= n_rd_idx;
        r_out     <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

FILE: rtl/positional_list_insert_delete_unit.sv
// top level of the positional list unit: stream ports around sequencer and memory
`default_nettype none
// Positional list unit. Keeps an ordered list of up to DEPTH signed 32-bit
// words in a single-port-write, registered-read memory plus an element count.
// Each command inserts (front, 1-based position, end), deletes (first,
// position, last), replaces at a position or just displays; a full list, an
// empty list or a bad position is reported in status and leaves the list as
// it was. After every command the whole list streams out in order, one
// transaction per element, with tlast on the final one; an empty list gives
// one status-only transaction. Commands are taken one at a time: a command
// that writes the list first moves the entries that must shift one slot
// over, reading each entry and writing it back, then does the final write
// and count update; the list then streams out, each element read from the
// registered memory before it is sent. The list's read and write port is
// the limit. A new command may be accepted while the last result still
// waits in the output register.
module positional_list_insert_delete_unit
    import plp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // position[4:0], value[36:5], zero pad
    input  wire logic [2:0]  s_axis_tuser,   // action[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // element[31:0], index[35:32], zero pad
    output logic [2:0]       m_axis_tuser,   // has_element[0], status[2:1]
    output logic             m_axis_tlast
);

    t_mem_req    mem_req;
    logic [31:0] mem_rdata;
    t_result     result;
    t_action     action;

    // action code rides in tuser
    assign action = t_action'(s_axis_tuser);

    plp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_action   (action),
        .i_position (s_axis_tdata[4:0]),
        .i_value    (s_axis_tdata[36:5]),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (result),
        .o_mem      (mem_req),
        .i_rdata    (mem_rdata)
    );

    // list storage, entries undefined until written
    plp_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // result packing
    assign m_axis_tdata = {4'b0000, result.index, result.element};
    assign m_axis_tuser = {result.status, result.has_element};
    assign m_axis_tlast = result.last;

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// self-checking testbench of the positional list unit: directed and random commands
`default_nettype none
module testbench
    import plp_pkg::*;
();

    // one command as the source side offers it, plus the pacing marks it carries
    typedef struct {
        t_action     action;
        logic [4:0]  position;
        logic [31:0] value;
        int          idle_phase;   // selects the idle mix on both sides
        bit          drain_first;  // hold this command back until the list output is quiet
        bit          stall_sink;   // start the long sink hold-off when this one goes out
    } t_list_cmd;

    localparam int RANDOM_CMDS      = 346;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 2 * DEPTH + 8;
    // idle chance in percent per phase: source, then sink
    localparam int SRC_IDLE [3]     = '{22, 68, 0};
    localparam int SINK_IDLE [3]    = '{68, 22, 0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // position[4:0], value[36:5], zero pad
    logic [2:0]  s_axis_tuser = '0;   // action[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // element[31:0], index[35:32], zero pad
    logic [2:0]  m_axis_tuser;        // has_element[0], status[2:1]
    logic        m_axis_tlast;

    // commands waiting for the source side, and the one currently on the bus
    t_list_cmd pending_cmds[$];
    t_list_cmd cmd_on_bus;

    // predicted list contents, and the list rows still owed by the block
    logic signed [31:0] list_words [DEPTH];
    int                 list_len = 0;
    t_result            expected_rows[$];

    // shadow list used while building stimulus, to aim positions at valid slots
    logic signed [31:0] plan_words [DEPTH];
    int                 plan_len = 0;

    int mismatch_count = 0;
    int sink_idle_pct = SINK_IDLE[0];
    bit sink_hold_req = 1'b0;

    positional_list_insert_delete_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // applies one command to a list; full and empty take priority over a bad position
    function automatic t_status update_list(ref logic signed [31:0] words [DEPTH],
                                            ref int len, input t_list_cmd cmd);
        int slot;
        int k;
        slot = int'(cmd.position) - 1;   // position zero gives slot -1, never valid
        case (cmd.action)
            ACT_INS_FRONT, ACT_INS_AT, ACT_APPEND: begin
                if (cmd.action == ACT_INS_FRONT) slot = 0;
                if (cmd.action == ACT_APPEND) slot = len;
                if (len >= DEPTH) return ST_FULL;
                if (slot < 0 || slot > len) return ST_POS;
                for (k = len; k > slot; k--) words[k] = words[k - 1];
                words[slot] = cmd.value;
                len++;
            end
            ACT_DEL_FIRST, ACT_DEL_AT, ACT_DEL_LAST: begin
                if (cmd.action == ACT_DEL_FIRST) slot = 0;
                if (cmd.action == ACT_DEL_LAST) slot = len - 1;
                if (len == 0) return ST_EMPTY;
                if (slot < 0 || slot >= len) return ST_POS;
                for (k = slot; k + 1 < len; k++) words[k] = words[k + 1];
                len--;
            end
            ACT_REPLACE: begin
                if (len == 0) return ST_EMPTY;
                if (slot < 0 || slot >= len) return ST_POS;
                words[slot] = cmd.value;
            end
            default: begin
                // display leaves the list alone
            end
        endcase
        return ST_OK;
    endfunction

    // updates the predicted list and queues the rows the block must stream out
    task automatic apply_list_command(input t_list_cmd cmd);
        t_status st;
        t_result row;
        int k;
        st = update_list(list_words, list_len, cmd);
        row.status = st;
        if (list_len == 0) begin
            // empty list: a single status-only row
            row.element     = '0;
            row.index       = '0;
            row.has_element = 1'b0;
            row.last        = 1'b1;
            expected_rows.push_back(row);
        end else begin
            for (k = 0; k < list_len; k++) begin
                row.element     = list_words[k];
                row.index       = k[3:0];
                row.has_element = 1'b1;
                row.last        = (k + 1 == list_len);
                expected_rows.push_back(row);
            end
        end
    endtask

    task automatic queue_cmd(input t_action act, input int pos, input logic [31:0] word,
                             input int phase, input bit drain, input bit hold);
        t_list_cmd c;
        c.action      = act;
        c.position    = pos[4:0];
        c.value       = word;
        c.idle_phase  = phase;
        c.drain_first = drain;
        c.stall_sink  = hold;
        void'(update_list(plan_words, plan_len, c));
        pending_cmds.push_back(c);
    endtask

    // word mix that leans on the signed extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // source side: predicts on every accepted transaction, then offers the next command
    always @(posedge i_clk) begin
        t_list_cmd nxt;
        bit offer;
        bit hold_now;
        offer = 1'b0;
        hold_now = 1'b0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_list_command(cmd_on_bus);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() > 0) begin
                    nxt = pending_cmds[0];
                    offer = !(nxt.drain_first && expected_rows.size() > 0)
                            && ($urandom_range(99) >= SRC_IDLE[nxt.idle_phase]);
                end
                if (offer) begin
                    cmd_on_bus = pending_cmds.pop_front();
                    hold_now = cmd_on_bus.stall_sink;
                    s_axis_tdata <= {3'b000, cmd_on_bus.value, cmd_on_bus.position};
                    s_axis_tuser <= cmd_on_bus.action;
                    sink_idle_pct <= SINK_IDLE[cmd_on_bus.idle_phase];
                end
                s_axis_tvalid <= offer;
            end
        end
        sink_hold_req <= hold_now;
    end

    // sink readiness: random idling, and a long hold-off counted here on request
    always @(posedge i_clk) begin
        int hold_left;
        if (!i_rst_n) begin
            hold_left = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (sink_hold_req) hold_left = SINK_HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // result checker: each accepted row against the oldest predicted row
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.element     = m_axis_tdata[31:0];
            got.index       = m_axis_tdata[35:32];
            got.has_element = m_axis_tuser[0];
            got.status      = t_status'(m_axis_tuser[2:1]);
            got.last        = m_axis_tlast;
            if (expected_rows.size() == 0) begin
                $error("unexpected row: element %0d index %0d status %0d",
                       got.element, got.index, got.status);
                mismatch_count++;
            end else begin
                want = expected_rows.pop_front();
                if (got.element !== want.element) begin
                    $error("element: expected %0d, got %0d", want.element, got.element);
                    mismatch_count++;
                end
                if (got.index !== want.index) begin
                    $error("index: expected %0d, got %0d", want.index, got.index);
                    mismatch_count++;
                end
                if (got.has_element !== want.has_element) begin
                    $error("has_element: expected %0d, got %0d",
                           want.has_element, got.has_element);
                    mismatch_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatch_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus plan, then wait for the block to drain and report
    initial begin
        t_action act;
        int n;
        int trend;
        int roll;
        int ins_pct;
        int del_pct;
        int hi;
        int pos;
        int phase;

        // directed: everything on an empty list first
        queue_cmd(ACT_DISPLAY,   1, 32'd0, 0, 1'b0, 1'b0);
        queue_cmd(ACT_DEL_FIRST, 1, 32'd0, 0, 1'b0, 1'b0);
        queue_cmd(ACT_DEL_AT,    1, 32'd0, 0, 1'b0, 1'b0);
        queue_cmd(ACT_DEL_LAST,  1, 32'd0, 0, 1'b0, 1'b0);
        queue_cmd(ACT_REPLACE,   1, 32'd9, 0, 1'b0, 1'b0);
        // insert at position zero and one past the end are both rejected
        queue_cmd(ACT_INS_AT,    0, 32'd5, 0, 1'b0, 1'b0);
        queue_cmd(ACT_INS_AT,    2, 32'd5, 0, 1'b0, 1'b0);
        // build a list of extremes
        queue_cmd(ACT_INS_AT,    1, 32'h7fff_ffff, 0, 1'b0, 1'b0);
        queue_cmd(ACT_INS_FRONT, 1, 32'h8000_0000, 0, 1'b0, 1'b0);
        queue_cmd(ACT_APPEND,    1, 32'hffff_ffff, 0, 1'b0, 1'b0);
        queue_cmd(ACT_APPEND,    1, 32'h0000_0000, 0, 1'b0, 1'b0);
        // insert at count+1 is the last legal slot
        queue_cmd(ACT_INS_AT,    5, 32'h5555_5555, 0, 1'b0, 1'b0);
        queue_cmd(ACT_INS_AT,    3, 32'haaaa_aaaa, 0, 1'b0, 1'b0);
        queue_cmd(ACT_INS_AT,   31, 32'd1, 0, 1'b0, 1'b0);
        // replace at the last entry, past it, and at zero
        queue_cmd(ACT_REPLACE,   6, 32'd1, 0, 1'b0, 1'b0);
        queue_cmd(ACT_REPLACE,   7, 32'd2, 0, 1'b0, 1'b0);
        queue_cmd(ACT_REPLACE,   0, 32'd3, 0, 1'b0, 1'b0);
        queue_cmd(ACT_DEL_AT,    0, 32'd0, 0, 1'b0, 1'b0);
        queue_cmd(ACT_DEL_AT,    7, 32'd0, 0, 1'b0, 1'b0);
        queue_cmd(ACT_DEL_AT,    3, 32'd0, 0, 1'b0, 1'b0);
        queue_cmd(ACT_DEL_AT,    5, 32'd0, 0, 1'b0, 1'b0);
        queue_cmd(ACT_DEL_FIRST, 1, 32'd0, 0, 1'b0, 1'b0);
        queue_cmd(ACT_DEL_LAST,  1, 32'd0, 0, 1'b0, 1'b0);
        queue_cmd(ACT_DISPLAY,  17, 32'd0, 0, 1'b0, 1'b0);

        // random: stretches that grow, shrink or mix, so full and empty come up often
        for (n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 40 == 0) trend = $urandom_range(2);
            ins_pct = (trend == 0) ? 75 : (trend == 1) ? 15 : 40;
            del_pct = (trend == 0) ? 12 : (trend == 1) ? 72 : 40;
            roll = $urandom_range(99);
            if (roll < ins_pct) begin
                act = t_action'($urandom_range(2, 0));
            end else if (roll < ins_pct + del_pct) begin
                act = t_action'($urandom_range(5, 3));
            end else if (roll < ins_pct + del_pct + 8) begin
                act = ACT_REPLACE;
            end else begin
                act = ACT_DISPLAY;
            end
            // mostly a legal slot for the current length, sometimes anything at all
            hi = (act == ACT_INS_AT) ? plan_len + 1 : plan_len;
            if (hi >= 1 && $urandom_range(99) < 85) begin
                pos = $urandom_range(hi, 1);
            end else begin
                pos = $urandom_range(31, 0);
            end
            phase = (n < 115) ? 0 : (n < 230) ? 1 : 2;
            queue_cmd(act, pos, pick_word(), phase, (n % 50 == 0),
                      (n == 60 || n == 200 || n == 300));
        end

        wait (i_rst_n);
        while (pending_cmds.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_rows.size() > 0) @(posedge i_clk);
        // catch any stray rows after the last expected one
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #(4_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
